// ===== sv/cht_pkg.sv =====
// Package with the shared constants, codes and types of the chained hash table.
package cht_pkg;
    localparam int BUCKETS    = 16;
    localparam int POOL_NODES = 64;
    localparam int BW = $clog2(BUCKETS);
    localparam int PW = $clog2(POOL_NODES + 1);
    localparam int AW = $clog2(POOL_NODES);
    localparam logic [PW-1:0] NIL = PW'(POOL_NODES);
    localparam int KEY_W = 31;
    localparam int PAY_W = 32;
    localparam int NODE_W = KEY_W + PAY_W + PW;
    localparam int STEP_W = $clog2(POOL_NODES + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_DELETED   = 3'd4;
    localparam logic [2:0] ST_POOL_FULL = 3'd5;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [3:0]       bucket;
        logic [PAY_W-1:0] found_payload;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture request, start at bucket head
        logic rd_node;    // issue read of node at cursor
        logic advance;    // prev <= cur, cur <= next of read node
        logic rd_free;    // read node at free head
        logic do_insert;  // allocate node, write it, link at head
        logic do_delete;  // unlink current node, push on free list
        logic do_fix;     // relink the predecessor of a deleted node
        logic respond;    // load result register
        logic [2:0] status;
    } t_cmd;

    typedef struct packed {
        logic cur_nil;
        logic hit;
        logic steps_done;
        logic free_nil;
        logic fresh_left;
    } t_sts;
endpackage

// ===== sv/cht_if.sv =====
// Valid/ready channel interface carrying one transfer type.
interface cht_req_if;
    import cht_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cht_rsp_if;
    import cht_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/chained_hash_table.sv =====
// Top level of the chained hash table: controller plus datapath.
// Usage: requests arrive on the req channel (op, key, payload); each one yields
// exactly one transfer on the rsp channel (status, bucket, found_payload).
// The bucket is the low bits of the key. Insert walks the bucket's chain for a
// duplicate, then takes a node from the free list or from the unused part of the
// pool and links it at the chain head. Search returns the payload of the match.
// Delete unlinks the match and pushes its node on the free list.
// The walk is set by the single node-memory port: per node, the read is issued,
// the data returns and its next pointer is latched, then the key is compared. An
// insert that runs off the chain end then allocates a node, and a delete that
// stops on a match unlinks it and then relinks the node's predecessor.
// One request is in flight at a time; the result register holds a finished
// transfer, and a new request is taken in the cycle that result leaves.
// Reset empties every bucket and the free list; node memory needs no clearing.
// When the receiver stalls, the result is held and no new request is accepted.
module chained_hash_table (
    input  logic i_clk,
    input  logic i_rst_n,
    cht_req_if.sink   i_req,
    cht_rsp_if.source o_rsp
);
    import cht_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_op        (i_req.data.op),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cht_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req.data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp.data)
    );
endmodule

// ===== sv/cht_ram.sv =====
// Generic single-port RAM with registered read.
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== sv/cht_datapath.sv =====
// Datapath: request registers, bucket heads, node memory, free list and result.
module cht_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cht_pkg::t_req i_req,
    input  cht_pkg::t_cmd i_cmd,
    output cht_pkg::t_sts o_sts,
    output cht_pkg::t_rsp o_rsp
);
    import cht_pkg::*;

    logic [KEY_W-1:0]  r_key;
    logic [PAY_W-1:0]  r_pay;
    logic [BW-1:0]     r_bkt;
    logic [PW-1:0]     r_cur, r_prev, r_free, r_fresh;
    logic [STEP_W-1:0] r_steps;
    logic [PW-1:0]     r_head [BUCKETS];
    logic [PW-1:0]     r_cur_next;
    t_rsp              r_rsp;
    // Record of the node before the cursor, for relinking it after a delete.
    logic [KEY_W-1:0]  r_pkey;
    logic [PAY_W-1:0]  r_ppay;

    logic              we;
    logic [AW-1:0]     addr;
    logic [NODE_W-1:0] wdata, rdata;
    logic [KEY_W-1:0]  rd_key;
    logic [PAY_W-1:0]  rd_pay;
    logic [PW-1:0]     rd_next;
    logic [PW-1:0]     alloc;
    logic [BW-1:0]     req_bkt;

    assign {rd_key, rd_pay, rd_next} = rdata;
    assign req_bkt = i_req.key[BW-1:0];
    assign alloc = (r_free != NIL) ? r_free : r_fresh;

    // Node memory port: one write or one read each cycle.
    always_comb begin
        we    = 1'b0;
        addr  = r_cur[AW-1:0];
        wdata = {rd_key, rd_pay, rd_next};
        if (i_cmd.rd_free) begin
            addr = r_free[AW-1:0];
        end else if (i_cmd.do_insert) begin
            we    = 1'b1;
            addr  = alloc[AW-1:0];
            wdata = {r_key, r_pay, r_head[r_bkt]};
        end else if (i_cmd.do_delete) begin
            // Current node goes onto the free list.
            we    = 1'b1;
            addr  = r_cur[AW-1:0];
            wdata = {r_key, r_pay, r_free};
        end else if (i_cmd.do_fix && (r_prev != NIL)) begin
            // Predecessor now points past the deleted node.
            we    = 1'b1;
            addr  = r_prev[AW-1:0];
            wdata = {r_pkey, r_ppay, r_cur_next};
        end
    end

    cht_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_nodes (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    assign o_sts.cur_nil    = (r_cur == NIL);
    assign o_sts.hit        = (rd_key == r_key);
    assign o_sts.steps_done = (r_steps == STEP_W'(POOL_NODES));
    assign o_sts.free_nil   = (r_free == NIL);
    assign o_sts.fresh_left = (r_fresh != NIL);
    assign o_rsp = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUCKETS; i++) begin
                r_head[i] <= NIL;
            end
            r_free  <= NIL;
            r_fresh <= '0;
        end else begin
            if (i_cmd.do_insert) begin
                r_head[r_bkt] <= alloc;
                if (r_free != NIL) begin
                    r_free <= rd_next;
                end else begin
                    r_fresh <= r_fresh + PW'(1);
                end
            end
            if (i_cmd.do_delete) begin
                // The node's next pointer was latched when it was read.
                if (r_prev == NIL) begin
                    r_head[r_bkt] <= r_cur_next;
                end
                r_free <= r_cur;
            end
        end
    end

    // Delete with a predecessor rewrites that node's next pointer in the following cycle.
    // To keep one port, the predecessor's record is held in registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= i_req.key;
            r_pay   <= i_req.payload;
            r_bkt   <= req_bkt;
            r_cur   <= r_head[req_bkt];
            r_prev  <= NIL;
            r_steps <= '0;
        end
        if (i_cmd.advance) begin
            r_prev  <= r_cur;
            r_pkey  <= rd_key;
            r_ppay  <= rd_pay;
            r_cur   <= rd_next;
            r_steps <= r_steps + STEP_W'(1);
        end
        if (i_cmd.respond) begin
            r_rsp.status        <= i_cmd.status;
            r_rsp.bucket        <= 4'(r_bkt);
            r_rsp.found_payload <= (i_cmd.status == ST_FOUND) ? rd_pay : '0;
        end
    end

    // Latch the next pointer of the node under the cursor once its read returns.
    logic r_rd_pend;
    always_ff @(posedge i_clk) begin
        r_rd_pend <= i_cmd.rd_node;
        if (r_rd_pend) begin
            r_cur_next <= rd_next;
        end
    end
endmodule

// ===== sv/cht_ctrl.sv =====
// Controller state machine sequencing chain walks and updates.
module cht_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  logic [1:0]    i_op,
    input  logic          i_rsp_ready,
    output logic          o_rsp_valid,
    input  cht_pkg::t_sts i_sts,
    output cht_pkg::t_cmd o_cmd
);
    import cht_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_WAIT  = 6'b000100,
        S_EVAL  = 6'b001000,
        S_ALLOC = 6'b010000,
        S_FIX   = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_op;
    logic       r_valid, n_valid;

    assign o_req_ready = (r_state == S_IDLE) && (!r_valid || i_rsp_ready);
    assign o_rsp_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_rsp_ready;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && o_req_ready) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.cur_nil || i_sts.steps_done) begin
                    if (r_op == OP_INSERT) begin
                        o_cmd.rd_free = 1'b1;
                        n_state = S_ALLOC;
                    end else begin
                        o_cmd.respond = 1'b1;
                        o_cmd.status  = ST_NOT_FOUND;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.rd_node = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: n_state = S_EVAL;
            S_EVAL: begin
                if (i_sts.hit) begin
                    unique case (r_op)
                        OP_INSERT: begin
                            o_cmd.respond = 1'b1;
                            o_cmd.status  = ST_DUPLICATE;
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                        OP_SEARCH: begin
                            o_cmd.respond = 1'b1;
                            o_cmd.status  = ST_FOUND;
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                        OP_DELETE: begin
                            o_cmd.do_delete = 1'b1;
                            n_state = S_FIX;
                        end
                        default: begin
                            o_cmd.respond = 1'b1;
                            o_cmd.status  = ST_NOT_FOUND;
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                    endcase
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_ALLOC: begin
                o_cmd.respond = 1'b1;
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (!i_sts.free_nil || i_sts.fresh_left) begin
                    o_cmd.do_insert = 1'b1;
                    o_cmd.status = ST_INSERTED;
                end else begin
                    o_cmd.status = ST_POOL_FULL;
                end
            end
            S_FIX: begin
                o_cmd.do_fix  = 1'b1;
                o_cmd.respond = 1'b1;
                o_cmd.status  = ST_DELETED;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd.load) begin
            r_op <= i_op;
        end
    end
endmodule

// ===== dv/chained_hash_table_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the chained hash table: random and directed requests against a scoreboard.

// Keeps a behavioral copy of the table and the responses still owed by the block.
class cht_scoreboard;
    logic [cht_pkg::PW-1:0]    head_of_bucket [cht_pkg::BUCKETS];
    logic [cht_pkg::KEY_W-1:0] key_of_node    [cht_pkg::POOL_NODES];
    logic [cht_pkg::PAY_W-1:0] pay_of_node    [cht_pkg::POOL_NODES];
    logic [cht_pkg::PW-1:0]    link_of_node   [cht_pkg::POOL_NODES];
    int unsigned               next_unused;
    logic [cht_pkg::PW-1:0]    free_top;
    cht_pkg::t_rsp             owed_rsp [$];
    int                        live_count;

    function new();
        for (int i = 0; i < cht_pkg::BUCKETS; i++) head_of_bucket[i] = cht_pkg::NIL;
        next_unused = 0;
        free_top    = cht_pkg::NIL;
        live_count  = 0;
    endfunction

    // Walks bucket b and returns the node that holds k, or NIL.
    function logic [cht_pkg::PW-1:0] locate(int b, logic [cht_pkg::KEY_W-1:0] k);
        logic [cht_pkg::PW-1:0] p;
        p = head_of_bucket[b];
        for (int s = 0; s < cht_pkg::POOL_NODES && p != cht_pkg::NIL; s++) begin
            if (key_of_node[p] == k) return p;
            p = link_of_node[p];
        end
        return cht_pkg::NIL;
    endfunction

    // Applies an accepted request to the table copy and queues its expected response.
    function void note_request(cht_pkg::t_req r);
        cht_pkg::t_rsp          e;
        logic [cht_pkg::PW-1:0] n, prv, p;
        int                     b;
        b = r.key % cht_pkg::BUCKETS;
        e.status        = cht_pkg::ST_NOT_FOUND;
        e.bucket        = 4'(b);
        e.found_payload = '0;
        if (r.op == cht_pkg::OP_INSERT) begin
            if (locate(b, r.key) != cht_pkg::NIL) begin
                e.status = cht_pkg::ST_DUPLICATE;
            end else begin
                n = cht_pkg::NIL;
                if (free_top != cht_pkg::NIL) begin
                    n = free_top;
                    free_top = link_of_node[n];
                end else if (next_unused < cht_pkg::POOL_NODES) begin
                    n = cht_pkg::PW'(next_unused);
                    next_unused++;
                end
                if (n != cht_pkg::NIL) begin
                    key_of_node[n]    = r.key;
                    pay_of_node[n]    = r.payload;
                    link_of_node[n]   = head_of_bucket[b];
                    head_of_bucket[b] = n;
                    e.status = cht_pkg::ST_INSERTED;
                    live_count++;
                end else begin
                    e.status = cht_pkg::ST_POOL_FULL;
                end
            end
        end else if (r.op == cht_pkg::OP_SEARCH) begin
            n = locate(b, r.key);
            if (n != cht_pkg::NIL) begin
                e.status        = cht_pkg::ST_FOUND;
                e.found_payload = pay_of_node[n];
            end
        end else if (r.op == cht_pkg::OP_DELETE) begin
            prv = cht_pkg::NIL;
            p   = head_of_bucket[b];
            for (int s = 0; s < cht_pkg::POOL_NODES && p != cht_pkg::NIL; s++) begin
                if (key_of_node[p] == r.key) begin
                    if (prv != cht_pkg::NIL) link_of_node[prv] = link_of_node[p];
                    else head_of_bucket[b] = link_of_node[p];
                    link_of_node[p] = free_top;
                    free_top = p;
                    e.status = cht_pkg::ST_DELETED;
                    live_count--;
                    break;
                end
                prv = p;
                p   = link_of_node[p];
            end
        end
        owed_rsp.push_back(e);
    endfunction

    // Compares a response with the oldest one owed; returns a message or an empty string.
    function string check_response(cht_pkg::t_rsp got);
        cht_pkg::t_rsp e;
        if (owed_rsp.size() == 0) return $sformatf("unexpected response %p", got);
        e = owed_rsp.pop_front();
        if (got.status != e.status || got.bucket != e.bucket
                || got.found_payload != e.found_payload)
            return $sformatf("got %p, wanted %p", got, e);
        return "";
    endfunction
endclass

module chained_hash_table_tb;
    import cht_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_REQS = 1550;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    cht_req_if req_ch ();
    cht_rsp_if rsp_ch ();

    chained_hash_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #1 i_clk = ~i_clk;

    cht_scoreboard table_model = new();
    int  fail_count = 0;
    int  cycle_count = 0;
    int  sink_hold = 0;     // cycles the sink still keeps ready low
    bit  quiet_sink = 0;    // while set, the sink keeps ready high with no stalls
    logic [KEY_W-1:0] key_pool [32];

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
    end

    task automatic report(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    // Short gaps mostly, a long one now and then, none at all in quiet stretches.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one request and holds it until the block takes the transfer. Valid stays
    // high afterwards unless a gap follows, so back-to-back requests need no toggle.
    task automatic send_request(logic [1:0] op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] pay,
                                bit no_gap = 0);
        t_req r;
        int   g;
        g = no_gap ? 0 : gap_length();
        if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        r.op = op;
        r.key = k;
        r.payload = pay;
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        table_model.note_request(r);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (table_model.owed_rsp.size() != 0) @(posedge i_clk);
    endtask

    // Response side: random stalls on ready, with checking on each accepted transfer.
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                msg = table_model.check_response(rsp_ch.data);
                if (msg != "") report(msg);
            end
            if (quiet_sink) begin
                rsp_ch.ready <= 1'b1;
            end else if (sink_hold > 0) begin
                rsp_ch.ready <= 1'b0;
                sink_hold <= sink_hold - 1;
            end else begin
                rsp_ch.ready <= 1'b1;
                sink_hold <= gap_length();
            end
        end
    end

    // Cycle counter with a hard limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Picks a key that often lands on one already used, so chains grow and hits happen.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 31)];
        return KEY_W'($urandom());
    endfunction

    initial begin
        logic [1:0] op;
        int         r;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Keys spread over a few buckets; several share one so chains get long.
        foreach (key_pool[i])
            key_pool[i] = KEY_W'({$urandom_range(0, 2**26), 4'($urandom_range(0, 5))});
        key_pool[0] = '0;
        key_pool[1] = {KEY_W{1'b1}};

        // Directed part: key extremes, each operation, the unused code, absent deletes.
        send_request(OP_SEARCH, '0, '1);
        send_request(OP_DELETE, '0, '0);
        send_request(OP_INSERT, '0, '1);
        send_request(OP_INSERT, {KEY_W{1'b1}}, '0);
        send_request(OP_INSERT, KEY_W'(16), 32'h5555_AAAA);
        send_request(OP_INSERT, KEY_W'(32), 32'hAAAA_5555);
        send_request(OP_INSERT, '0, 32'h1234_5678);
        send_request(OP_SEARCH, '0, '0);
        send_request(OP_SEARCH, KEY_W'(16), '0);
        send_request(OP_SEARCH, {KEY_W{1'b1}}, '0);
        send_request(2'd3, KEY_W'(16), '1);
        send_request(OP_SEARCH, KEY_W'(16), '0);
        send_request(OP_DELETE, KEY_W'(16), '0);    // middle of the chain
        send_request(OP_DELETE, KEY_W'(32), '0);    // head of the chain
        send_request(OP_DELETE, KEY_W'(48), '0);
        send_request(OP_SEARCH, '0, '0);
        send_request(OP_INSERT, KEY_W'(64), '1);    // reuses a freed node

        // Fill the pool, then probe it while full: a new key and a duplicate.
        quiet_sink = 1;
        for (int i = 0; i < POOL_NODES + 2; i++)
            send_request(OP_INSERT, KEY_W'(1000 + i), $urandom(), 1);
        send_request(OP_INSERT, '0, '0);
        quiet_sink = 0;
        send_request(OP_SEARCH, KEY_W'(1000 + POOL_NODES - 5), '0);
        for (int i = 0; i < POOL_NODES + 2; i++)
            send_request(OP_DELETE, KEY_W'(1000 + i), '0);

        // Hold the sender until every owed response has come back.
        wait_drained();

        for (int n = 0; n < RANDOM_REQS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40) op = OP_INSERT;
            else if (r < 70) op = OP_SEARCH;
            else if (r < 97) op = OP_DELETE;
            else op = 2'd3;
            // Bias toward deletes when the pool is nearly full so it keeps cycling.
            if (op == OP_INSERT && table_model.live_count > 56 && $urandom_range(0, 1))
                op = OP_DELETE;
            quiet_sink = (n % 400) >= 350;
            send_request(op, pick_key(), $urandom(), quiet_sink);
            if (n == 900) wait_drained();
        end
        quiet_sink = 0;

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
